// ===== design/jvcm_pkg.sv =====
package jvcm_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int CMD_W   = 16;
    localparam int STEP_W  = 15;
    localparam int OFS_W   = 24;
    localparam int FRAC_W  = 8;
    localparam int EFF_W   = 32;
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic signed [OFS_W:0] OFS_MAX = (OFS_W + 1)'((1 << (OFS_W - 1)) - 1);
    localparam logic signed [OFS_W:0] OFS_MIN = (OFS_W + 1)'(-(1 << (OFS_W - 1)));

    localparam logic [CFG_ADDR_W-1:0] REG_BASE_LINEAR   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_LINEAR    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_ANGULAR  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_ANGULAR   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_LINEAR   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_ANGULAR  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE_LINEAR  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE_ANGULAR = 3'd7;

    typedef struct packed {
        logic       angular_adjust;
        logic       linear_adjust;
        logic       step_down;
        logic       step_up;
        logic       leave_cruise;
        logic       cruise;
        logic       stop_tail;
        logic [1:0] n_compute;
    } jvcm_job_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_STOP1,
        BK_MUL_LO,
        BK_MUL_AO,
        BK_MUL_LA,
        BK_MUL_AA,
        BK_ANG_RES,
        BK_EMIT,
        BK_LIN,
        BK_STOP2
    } jvcm_back_state_t;

endpackage

// ===== design/jvcm_fifo.sv =====
module jvcm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== design/jvcm_front.sv =====
module jvcm_front
    import jvcm_pkg::*;
#(
    parameter int AXIS_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         btn_angular_adjust,
    input  logic                         btn_cruise,
    input  logic                         btn_manual,
    input  logic                         btn_linear_adjust,
    input  logic                         btn_step_down,
    input  logic                         btn_step_up,
    input  logic signed [AXIS_WIDTH-1:0] axis_turn_manual,
    input  logic signed [AXIS_WIDTH-1:0] axis_forward,
    input  logic signed [AXIS_WIDTH-1:0] axis_turn_cruise,
    input  logic                         jq_full,
    output logic                         jq_push,
    output jvcm_job_t                    jq_job,
    output logic signed [AXIS_WIDTH-1:0] jq_ax_lin,
    output logic signed [AXIS_WIDTH-1:0] jq_ax_ang
);

    logic cruise_reg, cruise_next;
    logic prev_cruise_reg, prev_down_reg, prev_up_reg;
    logic accept, cruise_rise, comp_cruise;

    assign full        = jq_full;
    assign accept      = push && !jq_full;
    assign jq_push     = accept;
    assign cruise_rise = btn_cruise && !prev_cruise_reg;
    assign cruise_next = cruise_rise ? !cruise_reg : cruise_reg;
    assign comp_cruise = !btn_cruise && cruise_next;

    always_comb
    begin
        jq_job.angular_adjust = btn_angular_adjust;
        jq_job.linear_adjust  = btn_linear_adjust;
        jq_job.step_down      = btn_step_down && !prev_down_reg;
        jq_job.step_up        = btn_step_up && !prev_up_reg;
        jq_job.leave_cruise   = cruise_rise && cruise_reg;
        jq_job.cruise         = cruise_next;
        jq_job.stop_tail      = !btn_cruise && !btn_manual && !cruise_next;
        jq_job.n_compute      = {1'b0, comp_cruise} + {1'b0, btn_manual};
        jq_ax_lin             = axis_forward;
        jq_ax_ang             = cruise_next ? axis_turn_cruise : axis_turn_manual;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cruise_reg      <= 1'b0;
            prev_cruise_reg <= 1'b0;
            prev_down_reg   <= 1'b0;
            prev_up_reg     <= 1'b0;
        end
        else if (accept)
        begin
            cruise_reg      <= cruise_next;
            prev_cruise_reg <= btn_cruise;
            prev_down_reg   <= btn_step_down;
            prev_up_reg     <= btn_step_up;
        end
    end

endmodule

// ===== design/jvcm_back.sv =====
module jvcm_back
    import jvcm_pkg::*;
#(
    parameter int SPEED_WIDTH = 16,
    parameter int AXIS_WIDTH  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [CFG_DATA_W-1:0]         cfg_wdata,
    input  logic                          jq_empty,
    input  jvcm_job_t                     jq_job,
    input  logic signed [AXIS_WIDTH-1:0]  jq_ax_lin,
    input  logic signed [AXIS_WIDTH-1:0]  jq_ax_ang,
    output logic                          jq_pop,
    input  logic                          res_full,
    output logic                          res_push,
    output logic signed [SPEED_WIDTH-1:0] res_linear,
    output logic signed [SPEED_WIDTH-1:0] res_angular,
    output logic                          res_is_stop,
    output logic                          res_last
);

    localparam logic signed [PROD_W-1:0] OFS_HALF = PROD_W'(1) << (FRAC_W - 1);
    localparam logic signed [PROD_W-1:0] AX_HALF  = PROD_W'(1) << (AXIS_WIDTH - 2);
    localparam logic signed [32:0] SPD_HI = (33'sd1 <<< (SPEED_WIDTH - 1)) - 33'sd1;
    localparam logic signed [32:0] SPD_LO = -SPD_HI - 33'sd1;

    jvcm_back_state_t state_reg, state_next;

    logic signed [CMD_W-1:0]      base_lin_reg, base_ang_reg, scale_lin_reg, scale_ang_reg;
    logic [STEP_W-1:0]            max_lin_reg, max_ang_reg, step_lin_reg, step_ang_reg;

    jvcm_job_t                    job_reg, job_next;
    logic signed [AXIS_WIDTH-1:0] ax_lin_reg, ax_lin_next, ax_ang_reg, ax_ang_next;
    logic signed [OFS_W-1:0]      lin_ofs_reg, lin_ofs_next, ang_ofs_reg, ang_ofs_next;
    logic signed [OFS_W-1:0]      ang_tmp;
    logic [3:0]                   locks_reg, locks_next;
    logic                         second_reg, second_next;
    logic signed [PROD_W-1:0]     prod_reg, mul_p;
    logic signed [MUL_A_W-1:0]    mul_a;
    logic signed [MUL_B_W-1:0]    mul_b;
    logic signed [EFF_W-1:0]      el_reg, el_next, ea_reg, ea_next;
    logic signed [CMD_W-1:0]      lin_res_reg, lin_res_next, ang_res_reg, ang_res_next;
    logic signed [CMD_W-1:0]      out_lin, out_ang;
    logic                         emit_final;

    function automatic logic signed [OFS_W-1:0] ofs_step(
        input logic signed [OFS_W-1:0] ofs,
        input logic [STEP_W-1:0]       step,
        input logic                    down
    );
        logic signed [OFS_W:0] wide;
        logic signed [OFS_W:0] delta;
        logic signed [OFS_W:0] sum;
        wide  = $signed({ofs[OFS_W-1], ofs});
        delta = $signed({{(OFS_W + 1 - STEP_W){1'b0}}, step});
        sum   = down ? (wide - delta) : (wide + delta);
        if (sum > OFS_MAX)
        begin
            sum = OFS_MAX;
        end
        else if (sum < OFS_MIN)
        begin
            sum = OFS_MIN;
        end
        return sum[OFS_W-1:0];
    endfunction

    function automatic logic signed [EFF_W-1:0] eff_speed(
        input logic signed [CMD_W-1:0]  base,
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] r;
        r = (p + OFS_HALF) >>> FRAC_W;
        return $signed({{(EFF_W - CMD_W){base[CMD_W-1]}}, base}) + $signed(r[EFF_W-1:0]);
    endfunction

    function automatic logic signed [CMD_W-1:0] by_axis(
        input logic signed [PROD_W-1:0]     p,
        input logic signed [AXIS_WIDTH-1:0] ax,
        input logic [STEP_W-1:0]            maxv
    );
        logic signed [PROD_W-1:0] r;
        logic signed [PROD_W-1:0] lim;
        r   = (p + AX_HALF) >>> (AXIS_WIDTH - 1);
        lim = $signed({{(PROD_W - STEP_W){1'b0}}, maxv});
        if (ax == '0)
        begin
            r = '0;
        end
        else if (!ax[AXIS_WIDTH-1])
        begin
            if (r < 0)
            begin
                r = '0;
            end
            else if (r > lim)
            begin
                r = lim;
            end
        end
        else
        begin
            if (r > 0)
            begin
                r = '0;
            end
            else if (r < -lim)
            begin
                r = -lim;
            end
        end
        return r[CMD_W-1:0];
    endfunction

    function automatic logic signed [CMD_W-1:0] cruise_clamp(
        input logic signed [EFF_W-1:0] e,
        input logic [STEP_W-1:0]       maxv
    );
        logic signed [EFF_W-1:0] r;
        logic signed [EFF_W-1:0] lim;
        lim = $signed({{(EFF_W - STEP_W){1'b0}}, maxv});
        r   = e;
        if (e < 0)
        begin
            r = '0;
        end
        else if (e > lim)
        begin
            r = lim;
        end
        return r[CMD_W-1:0];
    endfunction

    function automatic logic signed [SPEED_WIDTH-1:0] sat_out(input logic signed [CMD_W-1:0] v);
        logic signed [32:0] w;
        w = $signed({{(33 - CMD_W){v[CMD_W-1]}}, v});
        if (w > SPD_HI)
        begin
            w = SPD_HI;
        end
        else if (w < SPD_LO)
        begin
            w = SPD_LO;
        end
        return w[SPEED_WIDTH-1:0];
    endfunction

    assign emit_final = (job_reg.n_compute == 2'd1) || second_reg;
    assign mul_p      = mul_a * mul_b;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!jq_empty)
                begin
                    if (jq_job.leave_cruise)
                    begin
                        state_next = BK_STOP1;
                    end
                    else if (jq_job.n_compute != 2'd0)
                    begin
                        state_next = BK_MUL_LO;
                    end
                    else
                    begin
                        state_next = BK_LIN;
                    end
                end
            end
            BK_STOP1:
            begin
                if (!res_full)
                begin
                    state_next = (job_reg.n_compute != 2'd0) ? BK_MUL_LO : BK_LIN;
                end
            end
            BK_MUL_LO:  state_next = BK_MUL_AO;
            BK_MUL_AO:  state_next = BK_MUL_LA;
            BK_MUL_LA:  state_next = BK_MUL_AA;
            BK_MUL_AA:  state_next = BK_ANG_RES;
            BK_ANG_RES: state_next = BK_EMIT;
            BK_EMIT:
            begin
                if (!res_full && emit_final)
                begin
                    state_next = BK_LIN;
                end
            end
            BK_LIN:
            begin
                state_next = job_reg.stop_tail ? BK_STOP2 : BK_IDLE;
            end
            BK_STOP2:
            begin
                if (!res_full)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        jq_pop      = 1'b0;
        res_push    = 1'b0;
        res_is_stop = 1'b0;
        res_last    = 1'b0;
        out_lin     = '0;
        out_ang     = '0;
        mul_a       = '0;
        mul_b       = '0;
        case (state_reg)
            BK_IDLE:
            begin
                jq_pop = !jq_empty;
            end
            BK_STOP1:
            begin
                res_push    = !res_full;
                res_is_stop = 1'b1;
                res_last    = (job_reg.n_compute == 2'd0);
            end
            BK_MUL_LO:
            begin
                mul_a = $signed({{(MUL_A_W - OFS_W){lin_ofs_reg[OFS_W-1]}}, lin_ofs_reg});
                mul_b = $signed({scale_lin_reg[CMD_W-1], scale_lin_reg});
            end
            BK_MUL_AO:
            begin
                mul_a = $signed({{(MUL_A_W - OFS_W){ang_ofs_reg[OFS_W-1]}}, ang_ofs_reg});
                mul_b = $signed({scale_ang_reg[CMD_W-1], scale_ang_reg});
            end
            BK_MUL_LA:
            begin
                mul_a = el_reg;
                mul_b = $signed({{(MUL_B_W - AXIS_WIDTH){ax_lin_reg[AXIS_WIDTH-1]}}, ax_lin_reg});
            end
            BK_MUL_AA:
            begin
                mul_a = ea_reg;
                mul_b = $signed({{(MUL_B_W - AXIS_WIDTH){ax_ang_reg[AXIS_WIDTH-1]}}, ax_ang_reg});
            end
            BK_EMIT:
            begin
                res_push = !res_full;
                res_last = emit_final;
                out_lin  = lin_res_reg;
                out_ang  = ang_res_reg;
            end
            BK_STOP2:
            begin
                res_push    = !res_full;
                res_is_stop = 1'b1;
                res_last    = 1'b1;
            end
            default:
            begin
                jq_pop = 1'b0;
            end
        endcase
        res_linear  = sat_out(out_lin);
        res_angular = sat_out(out_ang);
    end

    always_comb
    begin
        job_next     = job_reg;
        ax_lin_next  = ax_lin_reg;
        ax_ang_next  = ax_ang_reg;
        lin_ofs_next = lin_ofs_reg;
        ang_ofs_next = ang_ofs_reg;
        locks_next   = locks_reg;
        second_next  = second_reg;
        el_next      = el_reg;
        ea_next      = ea_reg;
        lin_res_next = lin_res_reg;
        ang_res_next = ang_res_reg;
        ang_tmp      = ang_ofs_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!jq_empty)
                begin
                    job_next    = jq_job;
                    ax_lin_next = jq_ax_lin;
                    ax_ang_next = jq_ax_ang;
                    second_next = 1'b0;
                    if (jq_job.angular_adjust && jq_job.step_down && !locks_reg[2])
                    begin
                        ang_tmp = ofs_step(ang_ofs_reg, step_ang_reg, 1'b1);
                    end
                    if (jq_job.angular_adjust && jq_job.step_up && !locks_reg[3])
                    begin
                        ang_tmp = ofs_step(ang_tmp, step_ang_reg, 1'b0);
                    end
                    ang_ofs_next = ang_tmp;
                    if (jq_job.leave_cruise)
                    begin
                        locks_next = '0;
                    end
                end
            end
            BK_MUL_AO:
            begin
                el_next = eff_speed(base_lin_reg, prod_reg);
            end
            BK_MUL_LA:
            begin
                ea_next = eff_speed(base_ang_reg, prod_reg);
            end
            BK_MUL_AA:
            begin
                lin_res_next = job_reg.cruise ? cruise_clamp(el_reg, max_lin_reg)
                                              : by_axis(prod_reg, ax_lin_reg, max_lin_reg);
                locks_next[0] = el_reg[EFF_W-1];
                locks_next[1] = el_reg > $signed({{(EFF_W - STEP_W){1'b0}}, max_lin_reg});
                locks_next[2] = ea_reg[EFF_W-1];
                locks_next[3] = ea_reg > $signed({{(EFF_W - STEP_W){1'b0}}, max_ang_reg});
            end
            BK_ANG_RES:
            begin
                ang_res_next = by_axis(prod_reg, ax_ang_reg, max_ang_reg);
            end
            BK_EMIT:
            begin
                if (!res_full && !emit_final)
                begin
                    second_next = 1'b1;
                end
            end
            BK_LIN:
            begin
                lin_ofs_next = lin_ofs_reg;
                if (job_reg.linear_adjust && job_reg.step_down && !locks_reg[0])
                begin
                    lin_ofs_next = ofs_step(lin_ofs_reg, step_lin_reg, 1'b1);
                end
                if (job_reg.linear_adjust && job_reg.step_up && !locks_reg[1])
                begin
                    lin_ofs_next = ofs_step(lin_ofs_next, step_lin_reg, 1'b0);
                end
            end
            default:
            begin
                second_next = second_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            lin_ofs_reg   <= '0;
            ang_ofs_reg   <= '0;
            locks_reg     <= '0;
            second_reg    <= 1'b0;
            base_lin_reg  <= 16'sd128;
            max_lin_reg   <= 15'd256;
            base_ang_reg  <= 16'sd128;
            max_ang_reg   <= 15'd256;
            step_lin_reg  <= 15'd26;
            step_ang_reg  <= 15'd26;
            scale_lin_reg <= 16'sd256;
            scale_ang_reg <= 16'sd256;
        end
        else
        begin
            state_reg   <= state_next;
            lin_ofs_reg <= lin_ofs_next;
            ang_ofs_reg <= ang_ofs_next;
            locks_reg   <= locks_next;
            second_reg  <= second_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_BASE_LINEAR:   base_lin_reg  <= $signed(cfg_wdata);
                    REG_MAX_LINEAR:    max_lin_reg   <= cfg_wdata[STEP_W-1:0];
                    REG_BASE_ANGULAR:  base_ang_reg  <= $signed(cfg_wdata);
                    REG_MAX_ANGULAR:   max_ang_reg   <= cfg_wdata[STEP_W-1:0];
                    REG_STEP_LINEAR:   step_lin_reg  <= cfg_wdata[STEP_W-1:0];
                    REG_STEP_ANGULAR:  step_ang_reg  <= cfg_wdata[STEP_W-1:0];
                    REG_SCALE_LINEAR:  scale_lin_reg <= $signed(cfg_wdata);
                    REG_SCALE_ANGULAR: scale_ang_reg <= $signed(cfg_wdata);
                    default:           base_lin_reg  <= base_lin_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg     <= job_next;
        ax_lin_reg  <= ax_lin_next;
        ax_ang_reg  <= ax_ang_next;
        prod_reg    <= mul_p;
        el_reg      <= el_next;
        ea_reg      <= ea_next;
        lin_res_reg <= lin_res_next;
        ang_res_reg <= ang_res_next;
    end

    a_leave_clears_locks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_IDLE && !jq_empty && jq_job.leave_cruise) |=> (locks_reg == '0))
        else $error("locks not cleared on leaving cruise");

    a_second_only_double: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> (job_reg.n_compute == 2'd2))
        else $error("second command on a single-command item");

    a_ang_ofs_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BK_IDLE) |=> $stable(ang_ofs_reg))
        else $error("angular offset moved outside item start");

    a_lin_ofs_lin_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BK_LIN) |=> $stable(lin_ofs_reg))
        else $error("linear offset moved outside linear step");

endmodule

// ===== design/joystick_velocity_command_mapper.sv =====
// Each item is taken from the job queue by the back end, which handles one item at a time;
// a stop for leaving cruise mode goes to the result queue before the command after it.
// Computed commands use the single multiplier of the back end, shared in sequence by its
// four products, so a new item is not taken until the last one is through.
// Reset (rst_n low, asynchronous): manual mode, button history, offsets and locks cleared,
// both queues emptied, registers back to their defaults.
module joystick_velocity_command_mapper
    import jvcm_pkg::*;
#(
    parameter int SPEED_WIDTH = 16,
    parameter int AXIS_WIDTH  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          btn_angular_adjust,
    input  logic                          btn_cruise,
    input  logic                          btn_manual,
    input  logic                          btn_linear_adjust,
    input  logic                          btn_step_down,
    input  logic                          btn_step_up,
    input  logic signed [AXIS_WIDTH-1:0]  axis_turn_manual,
    input  logic signed [AXIS_WIDTH-1:0]  axis_forward,
    input  logic signed [AXIS_WIDTH-1:0]  axis_turn_cruise,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [SPEED_WIDTH-1:0] linear_cmd,
    output logic signed [SPEED_WIDTH-1:0] angular_cmd,
    output logic                          is_stop,
    output logic                          last,
    input  logic                          cfg_we,
    input  logic [CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

    localparam int JOB_W   = $bits(jvcm_job_t) + 2 * AXIS_WIDTH;
    localparam int RES_W   = 2 * SPEED_WIDTH + 2;
    localparam int QUEUE_D = 2;

    jvcm_job_t                     fr_job, jq_job;
    logic signed [AXIS_WIDTH-1:0]  fr_ax_lin, fr_ax_ang, jq_ax_lin, jq_ax_ang;
    logic                          jq_push, jq_full, jq_pop, jq_empty;
    logic [JOB_W-1:0]              jq_wr_data, jq_rd_data;
    logic                          res_push, res_full, res_is_stop, res_last;
    logic signed [SPEED_WIDTH-1:0] res_linear, res_angular;
    logic [RES_W-1:0]              res_wr_data, res_rd_data;

    jvcm_front #(
        .AXIS_WIDTH (AXIS_WIDTH)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .btn_angular_adjust (btn_angular_adjust),
        .btn_cruise         (btn_cruise),
        .btn_manual         (btn_manual),
        .btn_linear_adjust  (btn_linear_adjust),
        .btn_step_down      (btn_step_down),
        .btn_step_up        (btn_step_up),
        .axis_turn_manual   (axis_turn_manual),
        .axis_forward       (axis_forward),
        .axis_turn_cruise   (axis_turn_cruise),
        .jq_full            (jq_full),
        .jq_push            (jq_push),
        .jq_job             (fr_job),
        .jq_ax_lin          (fr_ax_lin),
        .jq_ax_ang          (fr_ax_ang)
    );

    assign jq_wr_data = {fr_job, fr_ax_lin, fr_ax_ang};
    assign {jq_job, jq_ax_lin, jq_ax_ang} = jq_rd_data;

    jvcm_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_D)
    ) u_job_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (jq_push),
        .wr_data (jq_wr_data),
        .full    (jq_full),
        .pop     (jq_pop),
        .rd_data (jq_rd_data),
        .empty   (jq_empty)
    );

    jvcm_back #(
        .SPEED_WIDTH (SPEED_WIDTH),
        .AXIS_WIDTH  (AXIS_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .jq_empty    (jq_empty),
        .jq_job      (jq_job),
        .jq_ax_lin   (jq_ax_lin),
        .jq_ax_ang   (jq_ax_ang),
        .jq_pop      (jq_pop),
        .res_full    (res_full),
        .res_push    (res_push),
        .res_linear  (res_linear),
        .res_angular (res_angular),
        .res_is_stop (res_is_stop),
        .res_last    (res_last)
    );

    assign res_wr_data = {res_linear, res_angular, res_is_stop, res_last};
    assign {linear_cmd, angular_cmd, is_stop, last} = res_rd_data;

    jvcm_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_D)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_wr_data),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_rd_data),
        .empty   (empty)
    );

endmodule
